@@ design/smx_pkg.sv @@
`timescale 1ns / 1ps
package smx_pkg;

    localparam int unsigned STACK_DEPTH_DEF   = 256;
    localparam int unsigned LOCAL_COUNT_DEF   = 64;
    localparam int unsigned PROGRAM_DEPTH_DEF = 4096;
    localparam int unsigned MAX_KEEP_DEF      = 16;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MODE_W  = 5;
    localparam int unsigned KEEP_W  = 5;
    localparam int unsigned DROP_W  = 9;
    localparam int unsigned OPC_W   = 12;

    typedef enum logic [MODE_W-1:0] {
        OP_NOP      = 5'd0,
        OP_CONST    = 5'd1,
        OP_LGET     = 5'd2,
        OP_LSET     = 5'd3,
        OP_ADD      = 5'd4,
        OP_SUB      = 5'd5,
        OP_MUL      = 5'd6,
        OP_LT_S     = 5'd7,
        OP_GT_S     = 5'd8,
        OP_LE_S     = 5'd9,
        OP_GE_S     = 5'd10,
        OP_EQ       = 5'd11,
        OP_NE       = 5'd12,
        OP_LT_U     = 5'd13,
        OP_GT_U     = 5'd14,
        OP_LE_U     = 5'd15,
        OP_GE_U     = 5'd16,
        OP_EQZ      = 5'd17,
        OP_JUMP     = 5'd18,
        OP_JUMP_IF  = 5'd19,
        OP_JUMP_IFN = 5'd20,
        OP_RETURN   = 5'd21
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_MV_RD,
        ST_MV_WR,
        ST_TOP_RD,
        ST_TOP_CAP,
        ST_FIN
    } t_state;

endpackage

@@ design/smx_if.sv @@
`timescale 1ns / 1ps
interface smx_in_if;
    import smx_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [DATA_W-1:0]   immediate;
    logic [KEEP_W-1:0]   keep_count;
    logic [DROP_W-1:0]   drop_count;
    modport source (output valid, mode, immediate, keep_count, drop_count, input ready);
    modport sink   (input valid, mode, immediate, keep_count, drop_count, output ready);
endinterface

interface smx_out_if;
    import smx_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPC_W-1:0]    next_pc;
    logic [DATA_W-1:0]   top_value;
    logic                halted;
    logic                fault;
    modport source (output valid, next_pc, top_value, halted, fault, input ready);
    modport sink   (input valid, next_pc, top_value, halted, fault, output ready);
endinterface

@@ design/smx_ram.sv @@
`timescale 1ns / 1ps
module smx_ram #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/stack_machine_exec_unit.sv @@
`timescale 1ns / 1ps
// Plain instructions: accept in ST_IDLE, then execute against stack RAM in ST_EXEC.
// Taken branches add a read/write state pair per kept value moved, a top refetch, and
// a target reduction in ST_MOD when PROGRAM_DEPTH is not a power of two.
// One instruction in flight: a new one is accepted only in ST_IDLE.
// Reset: pc, stack height and halt cleared; stack and locals RAM not cleared.
module stack_machine_exec_unit #(
    parameter int unsigned STACK_DEPTH   = smx_pkg::STACK_DEPTH_DEF,
    parameter int unsigned LOCAL_COUNT   = smx_pkg::LOCAL_COUNT_DEF,
    parameter int unsigned PROGRAM_DEPTH = smx_pkg::PROGRAM_DEPTH_DEF,
    parameter int unsigned MAX_KEEP      = smx_pkg::MAX_KEEP_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    smx_in_if.sink     i_in,
    smx_out_if.source  o_out
);
    import smx_pkg::*;

    localparam int unsigned AW   = $clog2(STACK_DEPTH);
    localparam int unsigned HW   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned LW   = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int unsigned PCW  = $clog2(PROGRAM_DEPTH);
    localparam int unsigned CW   = ((HW > 10) ? HW : 10) + 1;
    localparam bit          IS_POW2 = ((1 << PCW) == PROGRAM_DEPTH);
    localparam int unsigned SH   = DATA_W + PCW;
    localparam logic [2*DATA_W:0] RCP =
        ((65'd1 << SH) + 65'(PROGRAM_DEPTH) - 65'd1) / 65'(PROGRAM_DEPTH);
    localparam logic [DATA_W-1:0] RCP_LO = RCP[DATA_W-1:0];
    localparam bit                RCP_HI = RCP[DATA_W];

    t_state              r_state, n_state;
    logic [PCW-1:0]      r_pc, n_pc;
    logic [HW-1:0]       r_h, n_h;
    logic [DATA_W-1:0]   r_top, n_top;
    logic                r_halt, n_halt;
    logic                r_fault, n_fault;
    logic [MODE_W-1:0]   r_mode;
    logic [DATA_W-1:0]   r_imm;
    logic [KEEP_W-1:0]   r_keep;
    logic [DROP_W-1:0]   r_drop;
    logic [AW-1:0]       r_src, n_src;
    logic [AW-1:0]       r_dst, n_dst;
    logic [KEEP_W-1:0]   r_cnt, n_cnt;
    logic [HW-1:0]       r_newh, n_newh;
    logic [PCW-1:0]      r_rem, n_rem;
    logic [4:0]          r_bit, n_bit;
    logic [2*DATA_W-1:0] r_prod, n_prod;
    logic [DATA_W-1:0]   r_quo, n_quo;

    logic                r_ovalid;
    logic [OPC_W-1:0]    r_opc;
    logic [DATA_W-1:0]   r_otop;
    logic                r_ohalt;
    logic                r_ofault;

    logic                s_we;
    logic [AW-1:0]       s_waddr, s_raddr;
    logic [DATA_W-1:0]   s_wdata, s_rdata;
    logic                l_we;
    logic [LW-1:0]       l_waddr, l_raddr;
    logic [DATA_W-1:0]   l_wdata, l_rdata;

    logic                out_free, accept;
    logic [PCW-1:0]      pc_inc;
    logic [DATA_W-1:0]   a_val, b_val, alu_res;
    logic                lt_s, lt_u, eq_v;
    logic                bad_local, cond_taken, moves;
    logic [HW-1:0]       bh;
    logic [CW-1:0]       kd_sum;
    logic                br_fault;
    logic [2*DATA_W:0]   rcp_sum;
    logic [31:0]         pc_ext;

    smx_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    smx_ram #(.DEPTH(LOCAL_COUNT), .WIDTH(DATA_W), .AW(LW)) u_locals (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign pc_inc    = (r_pc == PCW'(PROGRAM_DEPTH - 1)) ? '0 : r_pc + 1'b1;
    assign a_val     = s_rdata;
    assign b_val     = r_top;
    assign lt_s      = $signed(a_val) < $signed(b_val);
    assign lt_u      = a_val < b_val;
    assign eq_v      = a_val == b_val;
    assign bad_local = r_imm >= DATA_W'(LOCAL_COUNT);
    assign cond_taken = (t_op'(r_mode) == OP_JUMP_IF) ? (r_top != '0) : (r_top == '0);
    assign moves     = (r_keep != '0) && (r_drop != '0);
    assign bh        = (t_op'(r_mode) == OP_JUMP) ? r_h : r_h - 1'b1;
    assign kd_sum    = CW'(r_keep) + CW'(r_drop);
    assign br_fault  = (9'(r_keep) > 9'(MAX_KEEP)) || (kd_sum > CW'(bh));
    assign rcp_sum   = {1'b0, r_prod}
                     + (RCP_HI ? {1'b0, r_imm, {DATA_W{1'b0}}} : '0);

    always_comb begin
        case (t_op'(r_mode))
            OP_ADD:  alu_res = a_val + b_val;
            OP_SUB:  alu_res = a_val - b_val;
            OP_MUL:  alu_res = a_val * b_val;
            OP_LT_S: alu_res = DATA_W'(lt_s);
            OP_GT_S: alu_res = DATA_W'(!lt_s && !eq_v);
            OP_LE_S: alu_res = DATA_W'(lt_s || eq_v);
            OP_GE_S: alu_res = DATA_W'(!lt_s);
            OP_EQ:   alu_res = DATA_W'(eq_v);
            OP_NE:   alu_res = DATA_W'(!eq_v);
            OP_LT_U: alu_res = DATA_W'(lt_u);
            OP_GT_U: alu_res = DATA_W'(!lt_u && !eq_v);
            OP_LE_U: alu_res = DATA_W'(lt_u || eq_v);
            default: alu_res = DATA_W'(!lt_u);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_h     = r_h;
        n_top   = r_top;
        n_halt  = r_halt;
        n_fault = r_fault;
        n_src   = r_src;
        n_dst   = r_dst;
        n_cnt   = r_cnt;
        n_newh  = r_newh;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_prod  = r_prod;
        n_quo   = r_quo;
        s_we    = 1'b0;
        s_waddr = r_h[AW-1:0];
        s_wdata = r_imm;
        s_raddr = AW'(r_h - HW'(2));
        l_we    = 1'b0;
        l_waddr = r_imm[LW-1:0];
        l_wdata = r_top;
        l_raddr = i_in.immediate[LW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_fault = 1'b0;
                n_state = out_free ? ST_IDLE : ST_FIN;
                if (!r_halt) begin
                    case (t_op'(r_mode))
                        OP_CONST, OP_LGET: begin
                            if (r_h >= HW'(STACK_DEPTH) ||
                                (t_op'(r_mode) == OP_LGET && bad_local)) begin
                                n_fault = 1'b1;
                            end else begin
                                s_we    = 1'b1;
                                s_wdata = (t_op'(r_mode) == OP_CONST) ? r_imm : l_rdata;
                                n_top   = s_wdata;
                                n_h     = r_h + 1'b1;
                                n_pc    = pc_inc;
                            end
                        end
                        OP_LSET: begin
                            if (r_h == '0 || bad_local) begin
                                n_fault = 1'b1;
                            end else begin
                                l_we  = 1'b1;
                                n_top = s_rdata;
                                n_h   = r_h - 1'b1;
                                n_pc  = pc_inc;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_LT_S, OP_GT_S, OP_LE_S, OP_GE_S,
                        OP_EQ, OP_NE, OP_LT_U, OP_GT_U, OP_LE_U, OP_GE_U: begin
                            if (r_h < HW'(2)) begin
                                n_fault = 1'b1;
                            end else begin
                                s_we    = 1'b1;
                                s_waddr = AW'(r_h - HW'(2));
                                s_wdata = alu_res;
                                n_top   = alu_res;
                                n_h     = r_h - 1'b1;
                                n_pc    = pc_inc;
                            end
                        end
                        OP_EQZ: begin
                            if (r_h == '0) begin
                                n_fault = 1'b1;
                            end else begin
                                s_we    = 1'b1;
                                s_waddr = AW'(r_h - 1'b1);
                                s_wdata = DATA_W'(r_top == '0);
                                n_top   = s_wdata;
                                n_pc    = pc_inc;
                            end
                        end
                        OP_JUMP, OP_JUMP_IF, OP_JUMP_IFN: begin
                            if (t_op'(r_mode) != OP_JUMP && r_h == '0) begin
                                n_fault = 1'b1;
                            end else if (t_op'(r_mode) != OP_JUMP && !cond_taken) begin
                                n_top = s_rdata;
                                n_h   = r_h - 1'b1;
                                n_pc  = pc_inc;
                            end else if (br_fault) begin
                                n_fault = 1'b1;
                            end else begin
                                n_src  = AW'(CW'(bh) - CW'(r_keep));
                                n_dst  = AW'(CW'(bh) - kd_sum);
                                n_cnt  = r_keep;
                                n_newh = HW'(CW'(bh) - CW'(r_drop));
                                n_bit  = 5'd2;
                                if (IS_POW2) begin
                                    n_rem   = r_imm[PCW-1:0];
                                    n_state = moves ? ST_MV_RD : ST_TOP_RD;
                                end else begin
                                    n_rem   = '0;
                                    n_state = ST_MOD;
                                end
                            end
                        end
                        OP_RETURN: begin
                            n_halt = 1'b1;
                        end
                        default: begin
                            n_pc = pc_inc;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                case (r_bit)
                    5'd2: begin
                        n_prod = (2*DATA_W)'(r_imm) * (2*DATA_W)'(RCP_LO);
                    end
                    5'd1: begin
                        n_quo = DATA_W'(rcp_sum >> SH);
                    end
                    default: begin
                        n_rem = PCW'(r_imm - DATA_W'(r_quo * DATA_W'(PROGRAM_DEPTH)));
                    end
                endcase
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = moves ? ST_MV_RD : ST_TOP_RD;
                end
            end
            ST_MV_RD: begin
                s_raddr = r_src;
                n_state = ST_MV_WR;
            end
            ST_MV_WR: begin
                s_we    = 1'b1;
                s_waddr = r_dst;
                s_wdata = s_rdata;
                n_src   = r_src + 1'b1;
                n_dst   = r_dst + 1'b1;
                n_cnt   = r_cnt - 1'b1;
                n_state = (r_cnt == KEEP_W'(1)) ? ST_TOP_RD : ST_MV_RD;
            end
            ST_TOP_RD: begin
                s_raddr = AW'(r_newh - 1'b1);
                if (r_newh == '0) begin
                    n_h     = '0;
                    n_pc    = r_rem;
                    n_state = out_free ? ST_IDLE : ST_FIN;
                end else begin
                    n_state = ST_TOP_CAP;
                end
            end
            ST_TOP_CAP: begin
                n_top   = s_rdata;
                n_h     = r_newh;
                n_pc    = r_rem;
                n_state = out_free ? ST_IDLE : ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign pc_ext = 32'(n_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_h      <= '0;
            r_halt   <= 1'b0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_h     <= n_h;
            r_halt  <= n_halt;
            r_fault <= n_fault;
            if (r_state != ST_IDLE && n_state == ST_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_cnt  <= n_cnt;
        r_newh <= n_newh;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_prod <= n_prod;
        r_quo  <= n_quo;
        if (accept) begin
            r_mode <= i_in.mode;
            r_imm  <= i_in.immediate;
            r_keep <= i_in.keep_count;
            r_drop <= i_in.drop_count;
        end
        if (r_state != ST_IDLE && n_state == ST_IDLE) begin
            r_opc    <= pc_ext[OPC_W-1:0];
            r_otop   <= (n_h != '0) ? n_top : '0;
            r_ohalt  <= n_halt;
            r_ofault <= n_fault;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.next_pc   = r_opc;
    assign o_out.top_value = r_otop;
    assign o_out.halted    = r_ohalt;
    assign o_out.fault     = r_ofault;
endmodule

@@ design/smx_chk.sv @@
`timescale 1ns / 1ps
module smx_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_halted,
    input logic i_out_fault
);
    logic r_seen_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_halt_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_halted && i_out_fault))
        else $error("halted result reports a fault");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_seen_halt) |-> (i_out_halted && !i_out_fault))
        else $error("result after halt is not a clean halted result");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");
endmodule

bind stack_machine_exec_unit smx_chk u_smx_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_halted (o_out.halted),
    .i_out_fault  (o_out.fault)
);

@@ tb/stack_machine_exec_unit_test.sv @@
`timescale 1ns / 1ps
module stack_machine_exec_unit_test;
    import smx_pkg::*;

    localparam int unsigned STK   = STACK_DEPTH_DEF;
    localparam int unsigned LOCS  = LOCAL_COUNT_DEF;
    localparam int unsigned KMAX  = MAX_KEEP_DEF;
    localparam int unsigned LIMIT = 1000000;
    localparam int unsigned N_RANDOM = 720;

    typedef struct {
        logic [OPC_W-1:0]  pc;
        logic [DATA_W-1:0] top;
        logic              halted;
        logic              fault;
    } t_step_result;

    class exec_scoreboard;
        logic [DATA_W-1:0] stk [STK];
        logic [DATA_W-1:0] locs [LOCS];
        bit                loc_written [LOCS];
        int unsigned       height;
        logic [OPC_W-1:0]  pc;
        bit                halt;
        t_step_result      pending [$];
        int unsigned       errors, n_in, n_out, n_fault, n_branch;

        function new();
            height = 0;
            pc = '0;
            halt = 0;
            foreach (loc_written[i]) loc_written[i] = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function bit branch(logic [DATA_W-1:0] target, int unsigned keep,
                            int unsigned drop);
            int unsigned h;
            h = height;
            if (keep > KMAX || keep + drop > h) return 0;
            for (int unsigned i = 0; i < keep; i++)
                stk[h - keep - drop + i] = stk[h - keep + i];
            height = h - drop;
            pc = target[OPC_W-1:0];
            n_branch++;
            return 1;
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] imm,
                                 logic [KEEP_W-1:0] keep, logic [DROP_W-1:0] drop);
            int unsigned h;
            bit flt, r;
            logic [DATA_W-1:0] a, b, v;
            t_step_result res;
            h = height;
            flt = 0;
            n_in++;
            if (!halt) begin
                case (t_op'(mode))
                    OP_CONST, OP_LGET: begin
                        if (h >= STK || (mode == OP_LGET && imm >= LOCS)) flt = 1;
                        else begin
                            stk[h] = (mode == OP_CONST) ? imm : locs[imm];
                            height = h + 1;
                            pc++;
                        end
                    end
                    OP_LSET: begin
                        if (h < 1 || imm >= LOCS) flt = 1;
                        else begin
                            locs[imm] = stk[h-1];
                            loc_written[imm] = 1;
                            height = h - 1;
                            pc++;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_LT_S, OP_GT_S, OP_LE_S, OP_GE_S, OP_EQ,
                    OP_NE, OP_LT_U, OP_GT_U, OP_LE_U, OP_GE_U: begin
                        if (h < 2) flt = 1;
                        else begin
                            a = stk[h-2];
                            b = stk[h-1];
                            case (t_op'(mode))
                                OP_ADD:  v = a + b;
                                OP_SUB:  v = a - b;
                                OP_MUL:  v = a * b;
                                OP_LT_S: v = $signed(a) <  $signed(b);
                                OP_GT_S: v = $signed(a) >  $signed(b);
                                OP_LE_S: v = $signed(a) <= $signed(b);
                                OP_GE_S: v = $signed(a) >= $signed(b);
                                OP_EQ:   v = a == b;
                                OP_NE:   v = a != b;
                                OP_LT_U: v = a <  b;
                                OP_GT_U: v = a >  b;
                                OP_LE_U: v = a <= b;
                                default: v = a >= b;
                            endcase
                            stk[h-2] = v;
                            height = h - 1;
                            pc++;
                        end
                    end
                    OP_EQZ: begin
                        if (h < 1) flt = 1;
                        else begin
                            stk[h-1] = (stk[h-1] == 0);
                            pc++;
                        end
                    end
                    OP_JUMP: flt = !branch(imm, keep, drop);
                    OP_JUMP_IF, OP_JUMP_IFN: begin
                        if (h < 1) flt = 1;
                        else begin
                            r = (mode == OP_JUMP_IF) ? (stk[h-1] != 0) : (stk[h-1] == 0);
                            height = h - 1;
                            if (r) begin
                                if (!branch(imm, keep, drop)) begin
                                    height = h;
                                    flt = 1;
                                end
                            end else pc++;
                        end
                    end
                    OP_RETURN: halt = 1;
                    default: pc++;
                endcase
            end
            if (flt) n_fault++;
            res.pc = pc;
            res.top = (height > 0) ? stk[height-1] : '0;
            res.halted = halt;
            res.fault = flt;
            pending.push_back(res);
        endfunction

        function void check_result(logic [OPC_W-1:0] pc_o, logic [DATA_W-1:0] top_o,
                                   logic halt_o, logic fault_o);
            t_step_result e;
            n_out++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected transaction pc=%0h top=%0h", pc_o, top_o));
                return;
            end
            e = pending.pop_front();
            if (pc_o !== e.pc)
                report($sformatf("#%0d next_pc %0h, want %0h", n_out, pc_o, e.pc));
            if (top_o !== e.top)
                report($sformatf("#%0d top_value %0h, want %0h", n_out, top_o, e.top));
            if (halt_o !== e.halted)
                report($sformatf("#%0d halted %0b, want %0b", n_out, halt_o, e.halted));
            if (fault_o !== e.fault)
                report($sformatf("#%0d fault %0b, want %0b", n_out, fault_o, e.fault));
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    smx_in_if  in_if ();
    smx_out_if out_if ();

    stack_machine_exec_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    exec_scoreboard sb = new();
    int unsigned send_idle = 8, recv_idle = 55;
    bit hold_req = 0;
    int unsigned cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.next_pc, out_if.top_value, out_if.halted, out_if.fault);

    initial begin
        out_if.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready = 0;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
            end
            out_if.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(t_op op, logic [DATA_W-1:0] imm, logic [KEEP_W-1:0] keep = '0,
                        logic [DROP_W-1:0] drop = '0, logic [MODE_W-1:0] raw = '0);
        int unsigned gap;
        gap = ($urandom_range(99) < send_idle) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid = 1;
        in_if.mode = (raw != 0) ? raw : op;
        in_if.immediate = imm;
        in_if.keep_count = keep;
        in_if.drop_count = drop;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(in_if.mode, imm, keep, drop);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_branch(t_op op);
        int unsigned h, keep, drop;
        h = sb.height - ((op == OP_JUMP) ? 0 : 1);
        if (sb.height == 0) h = 0;
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(31);
            drop = $urandom_range(511);
        end else begin
            keep = $urandom_range((h < KMAX) ? h : KMAX);
            drop = $urandom_range(h - keep);
        end
        send(op, $urandom, KEEP_W'(keep), DROP_W'(drop));
    endtask

    task automatic random_item();
        int unsigned sel, idx;
        sel = $urandom_range(99);
        if (sb.height < 2 && sel < 60) sel = 0;
        if (sb.height > 40 && sel < 30) sel = 50;
        if (sel < 25) send(OP_CONST, pick_value());
        else if (sel < 33) begin
            idx = $urandom_range(LOCS - 1);
            if ($urandom_range(9) == 0) send(OP_LGET, $urandom_range(32'hFFFF_FFFF, LOCS));
            else if (sb.loc_written[idx]) send(OP_LGET, idx);
            else send(OP_CONST, pick_value());
        end else if (sel < 40) begin
            send(OP_LSET, ($urandom_range(9) == 0) ? $urandom : $urandom_range(LOCS - 1));
        end else if (sel < 70) send(t_op'($urandom_range(OP_GE_U, OP_ADD)), $urandom);
        else if (sel < 74) send(OP_EQZ, $urandom);
        else if (sel < 90) random_branch(t_op'($urandom_range(OP_JUMP_IFN, OP_JUMP)));
        else if (sel < 94) send(OP_NOP, $urandom, KEEP_W'($urandom), DROP_W'($urandom));
        else if (sel < 97) send(OP_NOP, $urandom, KEEP_W'($urandom), DROP_W'($urandom),
                                MODE_W'($urandom_range(31, 22)));
        else random_branch(OP_JUMP);
    endtask

    task automatic fill_and_drain();
        while (sb.height < STK) send(OP_CONST, pick_value());
        send(OP_CONST, 32'h1234_5678);
        if (sb.loc_written[0]) send(OP_LGET, 0);
        if ($urandom_range(1)) send(OP_JUMP, $urandom, 0, DROP_W'(STK));
        else send(OP_JUMP, $urandom, 1, DROP_W'(STK - 1));
    endtask

    initial begin
        in_if.valid = 0;
        in_if.mode = '0;
        in_if.immediate = '0;
        in_if.keep_count = '0;
        in_if.drop_count = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(OP_ADD, 0);
        send(OP_LSET, 0);
        send(OP_EQZ, 0);
        send(OP_JUMP_IF, 5);
        send(OP_JUMP, 7, 1, 0);
        send(OP_NOP, 0, 0, 0, 5'd31);
        send(OP_CONST, 32'hFFFF_FFFF);
        send(OP_LSET, LOCS - 1);
        send(OP_CONST, 32'h8000_0000);
        send(OP_LSET, 0);
        send(OP_LGET, LOCS - 1);
        send(OP_LGET, 0);
        send(OP_LGET, LOCS);
        send(OP_LSET, 32'hFFFF_FFFF);
        for (int op = OP_ADD; op <= OP_GE_U; op++) begin
            send(OP_CONST, 32'h7FFF_FFFF);
            send(t_op'(op), 0);
        end
        send(OP_EQZ, 0);
        send(OP_JUMP, 32'hFFFF_FFFF, 17, 0);
        send(OP_CONST, 0);
        send(OP_JUMP_IFN, 32'h0000_0FFF, 1, 1);
        send(OP_CONST, 0);
        send(OP_JUMP_IF, 3);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 240) begin
                send_idle = 55;
                recv_idle = 8;
            end
            if (n == 480) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == 360) hold_req = 1;
            if (n % 360 == 100) fill_and_drain();
            random_item();
        end

        send(OP_RETURN, 0);
        send(OP_CONST, 32'hDEAD_BEEF);
        send(OP_JUMP, 1);
        @(negedge i_clk);
        in_if.valid = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("ran %0d instructions, %0d results, %0d faults, %0d taken branches",
                 sb.n_in, sb.n_out, sb.n_fault, sb.n_branch);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
